// ===== design/npclip_pkg.sv =====
// ----------------------------------------------------------------------------
// npclip_pkg
// Shared constants for the near plane triangle clipper.
// ----------------------------------------------------------------------------
package npclip_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int ATTR_NUM        = 9;
	localparam int COORD_ATTRS     = 6;
	localparam int COLOR_WIDTH     = 16;
	localparam int TRI_VERTS       = 3;
	localparam int POLY_MAX        = 4;
	localparam int FRAC_BITS       = 32;
	localparam int NORM_SHIFT      = 62;
	localparam int QUEUE_DEPTH     = 2;
	localparam int CFG_INDEX_WIDTH = 8;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_PLANE_A = 8'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_PLANE_B = 8'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_PLANE_C = 8'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_PLANE_D = 8'd3;

endpackage

// ===== design/near_plane_triangle_clipper.sv =====
// ----------------------------------------------------------------------------
// near_plane_triangle_clipper
// Clips a stream of triangles against one plane and emits a triangle list.
// ----------------------------------------------------------------------------
// Vertices are accepted one per transfer; every third vertex closes a triangle that is
// queued for the clip engine; the first two vertices are never held off, the third waits while the queue is full.
// The clip engine handles one triangle at a time: it computes the plane distances and walks
// the edges, then for each of the zero or two crossing edges it runs normalizing shifts,
// a 33-step restoring divider for the crossing fraction and a shared interpolating
// multiplier over the nine attributes, and finally it emits the clipped vertices.
// A two-entry queue lets the front end keep accepting vertices while the engine works.
module near_plane_triangle_clipper
	import npclip_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [COORD_WIDTH-1:0]     cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [COORD_WIDTH-1:0]     pos_x,
	input  logic [COORD_WIDTH-1:0]     pos_y,
	input  logic [COORD_WIDTH-1:0]     pos_z,
	input  logic [COORD_WIDTH-1:0]     pos_w,
	input  logic [COORD_WIDTH-1:0]     tex_u,
	input  logic [COORD_WIDTH-1:0]     tex_v,
	input  logic [COLOR_WIDTH-1:0]     red,
	input  logic [COLOR_WIDTH-1:0]     green,
	input  logic [COLOR_WIDTH-1:0]     blue,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [COORD_WIDTH-1:0]     out_x,
	output logic [COORD_WIDTH-1:0]     out_y,
	output logic [COORD_WIDTH-1:0]     out_z,
	output logic [COORD_WIDTH-1:0]     out_w,
	output logic [COORD_WIDTH-1:0]     out_u,
	output logic [COORD_WIDTH-1:0]     out_v,
	output logic [COLOR_WIDTH-1:0]     out_red,
	output logic [COLOR_WIDTH-1:0]     out_green,
	output logic [COLOR_WIDTH-1:0]     out_blue,
	output logic                       last_of_run
);

	localparam int AW = COORD_WIDTH + 1;
	localparam int TW = TRI_VERTS * ATTR_NUM * AW;

	logic [ATTR_NUM-1:0][AW-1:0]                in_vtx;
	logic [ATTR_NUM-1:0][AW-1:0]                res_vtx;
	logic [TRI_VERTS-1:0][ATTR_NUM-1:0][AW-1:0] fr_tri;
	logic [TRI_VERTS-1:0][ATTR_NUM-1:0][AW-1:0] bk_tri;
	logic                                       fr_valid;
	logic                                       fr_ready;
	logic                                       bk_valid;
	logic                                       bk_ready;

	assign in_vtx[0] = {pos_x[COORD_WIDTH-1], pos_x};
	assign in_vtx[1] = {pos_y[COORD_WIDTH-1], pos_y};
	assign in_vtx[2] = {pos_z[COORD_WIDTH-1], pos_z};
	assign in_vtx[3] = {pos_w[COORD_WIDTH-1], pos_w};
	assign in_vtx[4] = {tex_u[COORD_WIDTH-1], tex_u};
	assign in_vtx[5] = {tex_v[COORD_WIDTH-1], tex_v};
	assign in_vtx[6] = {{(AW-COLOR_WIDTH){1'b0}}, red};
	assign in_vtx[7] = {{(AW-COLOR_WIDTH){1'b0}}, green};
	assign in_vtx[8] = {{(AW-COLOR_WIDTH){1'b0}}, blue};

	assign out_x     = res_vtx[0][COORD_WIDTH-1:0];
	assign out_y     = res_vtx[1][COORD_WIDTH-1:0];
	assign out_z     = res_vtx[2][COORD_WIDTH-1:0];
	assign out_w     = res_vtx[3][COORD_WIDTH-1:0];
	assign out_u     = res_vtx[4][COORD_WIDTH-1:0];
	assign out_v     = res_vtx[5][COORD_WIDTH-1:0];
	assign out_red   = res_vtx[6][COLOR_WIDTH-1:0];
	assign out_green = res_vtx[7][COLOR_WIDTH-1:0];
	assign out_blue  = res_vtx[8][COLOR_WIDTH-1:0];

	npclip_front #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_vtx    (in_vtx),
		.tri_valid (fr_valid),
		.tri_ready (fr_ready),
		.tri_data  (fr_tri)
	);

	npclip_queue #(
		.WIDTH (TW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fr_valid),
		.wr_ready (fr_ready),
		.wr_data  (fr_tri),
		.rd_valid (bk_valid),
		.rd_ready (bk_ready),
		.rd_data  (bk_tri)
	);

	npclip_back #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tri_valid (bk_valid),
		.tri_ready (bk_ready),
		.tri_data  (bk_tri),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_vtx   (res_vtx),
		.out_last  (last_of_run)
	);

endmodule

// ===== design/npclip_queue.sv =====
// ----------------------------------------------------------------------------
// npclip_queue
// Short triangle queue between the vertex front end and the clip engine.
// ----------------------------------------------------------------------------
module npclip_queue
	import npclip_pkg::*;
#(
	parameter int WIDTH = 32,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    cnt_q;
	logic             push;
	logic             pop;

	assign wr_ready = (cnt_q != CW'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

endmodule

// ===== design/npclip_front.sv =====
// ----------------------------------------------------------------------------
// npclip_front
// Collects vertices and hands a complete triangle on with its third vertex.
// ----------------------------------------------------------------------------
module npclip_front
	import npclip_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       in_valid,
	output logic                                       in_ready,
	input  logic [ATTR_NUM-1:0][COORD_WIDTH:0]         in_vtx,
	output logic                                       tri_valid,
	input  logic                                       tri_ready,
	output logic [TRI_VERTS-1:0][ATTR_NUM-1:0][COORD_WIDTH:0] tri_data
);

	logic [1:0]                         count_q;
	logic [1:0][ATTR_NUM-1:0][COORD_WIDTH:0] held_q;
	logic                               last_vtx;

	assign last_vtx  = (count_q == 2'd2);
	assign in_ready  = !last_vtx || tri_ready;
	assign tri_valid = in_valid && last_vtx;
	assign tri_data  = {in_vtx, held_q[1], held_q[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (in_valid && in_ready) begin
			count_q <= last_vtx ? 2'd0 : count_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready && !last_vtx) begin
			held_q[count_q[0]] <= in_vtx;
		end
	end

endmodule

// ===== design/npclip_back.sv =====
// ----------------------------------------------------------------------------
// npclip_back
// Clip engine: plane distances, crossing fractions, interpolation and fan output.
// ----------------------------------------------------------------------------
module npclip_back
	import npclip_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       cfg_valid,
	output logic                                       cfg_ready,
	input  logic [CFG_INDEX_WIDTH-1:0]                 cfg_index,
	input  logic [COORD_WIDTH-1:0]                     cfg_data,
	input  logic                                       tri_valid,
	output logic                                       tri_ready,
	input  logic [TRI_VERTS-1:0][ATTR_NUM-1:0][COORD_WIDTH:0] tri_data,
	output logic                                       out_valid,
	input  logic                                       out_ready,
	output logic [ATTR_NUM-1:0][COORD_WIDTH:0]         out_vtx,
	output logic                                       out_last
);

	localparam int AW = COORD_WIDTH + 1;
	localparam int PW = 2 * COORD_WIDTH;
	localparam int DW = 2 * COORD_WIDTH + 3;
	localparam int QW = FRAC_BITS + 1;
	localparam int LW = AW + 1 + QW + 1;
	localparam int SW = COORD_WIDTH + 5;
	localparam logic signed [SW-1:0] SAT_MAX = {{6{1'b0}}, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [SW-1:0] SAT_MIN = {{6{1'b1}}, {(COORD_WIDTH-1){1'b0}}};
	localparam logic signed [SW-1:0] COL_MAX =
		{{(SW-COLOR_WIDTH){1'b0}}, {COLOR_WIDTH{1'b1}}};
	localparam logic [COORD_WIDTH-1:0] MINUS_ONE = COORD_WIDTH'(-65536);

	typedef enum logic [2:0] {
		S_IDLE, S_DIST, S_EDGE, S_NORM, S_DIV, S_LERP, S_XPUT, S_EMIT
	} state_t;

	typedef logic [ATTR_NUM-1:0][AW-1:0] vtx_t;

	state_t                           state_q;
	logic signed [COORD_WIDTH-1:0]    plane_q [4];
	logic [TRI_VERTS-1:0][ATTR_NUM-1:0][AW-1:0] tri_q;
	logic signed [DW-1:0]             dist_q [TRI_VERTS];
	logic [POLY_MAX-1:0][ATTR_NUM-1:0][AW-1:0] poly_q;
	vtx_t                             xv_q;
	logic [2:0]                       pn_q;
	logic [1:0]                       edge_q;
	logic                             xdone_q;
	logic [5:0]                       cnt_q;
	logic [DW-1:0]                    num_q;
	logic [DW-1:0]                    den_q;
	logic [DW:0]                      rem_q;
	logic [QW-1:0]                    frac_q;
	logic [2:0]                       k_q;
	logic                             out_valid_q;
	logic                             out_last_q;
	vtx_t                             out_vtx_q;

	logic signed [PW-1:0]             prod_s1;
	logic                             prod_vld_s1;
	logic [1:0]                       prod_vi_s1;
	logic                             prod_first_s1;
	logic signed [LW-1:0]             lprod_s1;
	logic signed [AW-1:0]             la_s1;
	logic [3:0]                       li_s1;
	logic                             lvld_s1;

	logic [1:0]                       ep;
	logic [1:0]                       ec;
	logic                             pin;
	logic                             cin;
	logic [2:0]                       pn_nx;
	logic [DW:0]                      div_nn;
	logic                             div_ge;
	logic signed [AW-1:0]             la;
	logic signed [AW-1:0]             lb;
	logic signed [AW:0]               ldiff;
	logic signed [LW-1:0]             lprod;
	logic signed [SW-1:0]             lsum;
	logic signed [SW-1:0]             lsat;
	logic                             emit_go;
	logic                             emit_last;

	function automatic logic [1:0] edge_prev(input logic [1:0] e);
		case (e)
			2'd0:    return 2'd1;
			2'd1:    return 2'd2;
			default: return 2'd0;
		endcase
	endfunction

	function automatic logic [1:0] edge_cur(input logic [1:0] e);
		case (e)
			2'd0:    return 2'd2;
			2'd1:    return 2'd0;
			default: return 2'd1;
		endcase
	endfunction

	function automatic logic [1:0] fan_src(input logic [2:0] k);
		case (k)
			3'd0:    return 2'd0;
			3'd1:    return 2'd1;
			3'd2:    return 2'd2;
			3'd3:    return 2'd0;
			3'd4:    return 2'd2;
			default: return 2'd3;
		endcase
	endfunction

	assign cfg_ready = 1'b1;
	assign tri_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_vtx   = out_vtx_q;
	assign out_last  = out_last_q;

	always_comb begin
		ep    = edge_prev(edge_q);
		ec    = edge_cur(edge_q);
		pin   = !dist_q[ep][DW-1];
		cin   = !dist_q[ec][DW-1];
		pn_nx = (cin && pn_q < 3'(POLY_MAX)) ? pn_q + 3'd1 : pn_q;

		div_nn = (cnt_q == '0) ? rem_q : {rem_q[DW-1:0], 1'b0};
		div_ge = (div_nn >= {1'b0, den_q});

		la    = $signed(tri_q[ep][cnt_q[3:0]]);
		lb    = $signed(tri_q[ec][cnt_q[3:0]]);
		ldiff = $signed({lb[AW-1], lb}) - $signed({la[AW-1], la});
		lprod = ldiff * $signed({1'b0, frac_q});

		lsum = $signed({{(SW-AW){la_s1[AW-1]}}, la_s1})
			+ $signed({lprod_s1[LW-1], lprod_s1[LW-1:FRAC_BITS]});
		if (li_s1 < 4'(COORD_ATTRS)) begin
			lsat = (lsum > SAT_MAX) ? SAT_MAX : ((lsum < SAT_MIN) ? SAT_MIN : lsum);
		end else begin
			lsat = (lsum > COL_MAX) ? COL_MAX : (lsum[SW-1] ? '0 : lsum);
		end

		emit_go   = !out_valid_q || out_ready;
		emit_last = ((pn_q == 3'd3) && (k_q == 3'd2)) || (k_q == 3'd5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q[0] <= '0;
			plane_q[1] <= '0;
			plane_q[2] <= MINUS_ONE;
			plane_q[3] <= MINUS_ONE;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PLANE_A: plane_q[0] <= cfg_data;
				REG_PLANE_B: plane_q[1] <= cfg_data;
				REG_PLANE_C: plane_q[2] <= cfg_data;
				REG_PLANE_D: plane_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			prod_vld_s1 <= 1'b0;
			lvld_s1     <= 1'b0;
			cnt_q       <= '0;
			edge_q      <= '0;
			xdone_q     <= 1'b0;
			pn_q        <= '0;
			k_q         <= '0;
		end else begin
			prod_vld_s1 <= (state_q == S_DIST) && (cnt_q < 6'd12);
			lvld_s1     <= (state_q == S_LERP) && (cnt_q < 6'(ATTR_NUM));
			if ((state_q == S_EMIT) && emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (tri_valid) begin
						tri_q   <= tri_data;
						cnt_q   <= '0;
						state_q <= S_DIST;
					end
				end
				S_DIST: begin
					if (cnt_q < 6'd12) begin
						prod_s1 <= plane_q[cnt_q[1:0]]
							* $signed(tri_q[cnt_q[3:2]][cnt_q[1:0]][COORD_WIDTH-1:0]);
						prod_vi_s1    <= cnt_q[3:2];
						prod_first_s1 <= (cnt_q[1:0] == 2'd0);
						cnt_q         <= cnt_q + 6'd1;
					end else begin
						edge_q  <= '0;
						xdone_q <= 1'b0;
						pn_q    <= '0;
						state_q <= S_EDGE;
					end
				end
				S_EDGE: begin
					if (pin != cin && !xdone_q) begin
						if (pin) begin
							num_q <= dist_q[ep];
							den_q <= dist_q[ep] - dist_q[ec];
						end else begin
							num_q <= -dist_q[ep];
							den_q <= dist_q[ec] - dist_q[ep];
						end
						state_q <= S_NORM;
					end else begin
						if (cin && pn_q < 3'(POLY_MAX)) begin
							poly_q[pn_q[1:0]] <= tri_q[ec];
						end
						pn_q    <= pn_nx;
						xdone_q <= 1'b0;
						edge_q  <= edge_q + 2'd1;
						if (edge_q == 2'd2) begin
							k_q     <= '0;
							state_q <= (pn_nx >= 3'd3) ? S_EMIT : S_IDLE;
						end
					end
				end
				S_NORM: begin
					if ((den_q >> NORM_SHIFT) != '0) begin
						num_q <= num_q >> 1;
						den_q <= den_q >> 1;
					end else begin
						rem_q   <= {1'b0, num_q};
						frac_q  <= '0;
						cnt_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q  <= div_ge ? div_nn - {1'b0, den_q} : div_nn;
					frac_q <= {frac_q[QW-2:0], div_ge};
					if (cnt_q == 6'(FRAC_BITS)) begin
						cnt_q   <= '0;
						state_q <= S_LERP;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_LERP: begin
					if (cnt_q < 6'(ATTR_NUM)) begin
						lprod_s1 <= lprod;
						la_s1    <= la;
						li_s1    <= cnt_q[3:0];
						cnt_q    <= cnt_q + 6'd1;
					end else begin
						state_q <= S_XPUT;
					end
				end
				S_XPUT: begin
					if (pn_q < 3'(POLY_MAX)) begin
						poly_q[pn_q[1:0]] <= xv_q;
						pn_q <= pn_q + 3'd1;
					end
					xdone_q <= 1'b1;
					state_q <= S_EDGE;
				end
				S_EMIT: begin
					if (emit_go) begin
						out_vtx_q   <= poly_q[fan_src(k_q)];
						out_last_q  <= emit_last;
						k_q         <= k_q + 3'd1;
						if (emit_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (prod_vld_s1) begin
			dist_q[prod_vi_s1] <= prod_first_s1
				? $signed({{3{prod_s1[PW-1]}}, prod_s1})
				: dist_q[prod_vi_s1] + $signed({{3{prod_s1[PW-1]}}, prod_s1});
		end
		if (lvld_s1) begin
			xv_q[li_s1] <= lsat[AW-1:0];
		end
	end

endmodule
